// ===== hdl/tehal_pkg.sv =====
package tehal_pkg;

    localparam int OP_W   = 3;
    localparam int ADDR_W = 23;
    localparam int ST_W   = 3;
    localparam int CNT_W  = 8;

    localparam logic [OP_W-1:0] OP_MARK    = 3'd0;
    localparam logic [OP_W-1:0] OP_P_ALLOC = 3'd1;
    localparam logic [OP_W-1:0] OP_P_RESET = 3'd2;
    localparam logic [OP_W-1:0] OP_T_ALLOC = 3'd3;
    localparam logic [OP_W-1:0] OP_T_FREE  = 3'd4;
    localparam logic [OP_W-1:0] OP_T_CHECK = 3'd5;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_SPACE    = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
    localparam logic [ST_W-1:0] ST_BADRESET = 3'd3;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;
    localparam logic [ST_W-1:0] ST_LIVE     = 3'd5;

    // decision of the combinational evaluator for one request
    typedef struct packed {
        logic [ST_W-1:0] status;
        logic            push;  // append new top offset to the live table
        logic            scan;  // temporary free: walk the live table
    } t_eval_flags;

endpackage

// ===== hdl/tehal_ifs.sv =====
interface tehal_req_if import tehal_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [ADDR_W-1:0] byte_count;
    logic [ADDR_W-1:0] address;

    modport source (output valid, opcode, byte_count, address, input ready);
    modport sink   (input valid, opcode, byte_count, address, output ready);
endinterface

interface tehal_rsp_if import tehal_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] result_address;
    logic [ST_W-1:0]   status;
    logic [ADDR_W-1:0] persistent_level;
    logic [ADDR_W-1:0] temp_level;
    logic [CNT_W-1:0]  temp_count;

    modport source (output valid, result_address, status, persistent_level, temp_level,
                    temp_count, input ready);
    modport sink   (input valid, result_address, status, persistent_level, temp_level,
                    temp_count, output ready);
endinterface

// ===== hdl/tehal_mem.sv =====
module tehal_mem import tehal_pkg::*; #(
    parameter int W     = 24,
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [W-1:0]  o_rdata_a,
    output logic [W-1:0]  o_rdata_b
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata_a;
    logic [W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== hdl/tehal_eval.sv =====
module tehal_eval import tehal_pkg::*; #(
    parameter int REGION_BYTES = 4194304,
    parameter int TEMP_SLOTS   = 128,
    parameter int LW           = 24,
    parameter int CW           = 8
) (
    input  logic [OP_W-1:0]   i_op,
    input  logic [ADDR_W-1:0] i_size,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic              i_align,
    input  logic [LW-1:0]     i_bottom,
    input  logic [LW-1:0]     i_top,
    input  logic [CW-1:0]     i_count,
    output logic [LW-1:0]     o_bottom,
    output logic [LW-1:0]     o_top,
    output logic [LW-1:0]     o_result,
    output logic [LW-1:0]     o_target,
    output t_eval_flags       o_flags
);

    localparam int RW   = ADDR_W + 1;
    localparam int SUMW = ((LW > RW) ? LW : RW) + 2;

    logic [LW-1:0]   base;
    logic [RW-1:0]   rounded;
    logic [SUMW-1:0] sum_p;
    logic [SUMW-1:0] sum_t;
    logic [LW-1:0]   top_new;
    logic            space_p;
    logic            space_t;
    logic            addr_over;

    always_comb begin
        base      = i_align ? ((i_bottom + LW'(3)) & ~LW'(3)) : i_bottom;
        rounded   = (RW'(i_size) + RW'(7)) & ~RW'(7);
        sum_p     = SUMW'(base) + SUMW'(i_top) + SUMW'(i_size);
        sum_t     = SUMW'(i_bottom) + SUMW'(i_top) + SUMW'(rounded);
        space_p   = sum_p >= SUMW'(REGION_BYTES);
        space_t   = sum_t >= SUMW'(REGION_BYTES);
        top_new   = i_top + LW'(rounded);
        addr_over = SUMW'(i_addr) > SUMW'(REGION_BYTES);

        o_bottom       = i_bottom;
        o_top          = i_top;
        o_result       = '0;
        o_target       = LW'(REGION_BYTES) - LW'(i_addr);
        o_flags.status = ST_OK;
        o_flags.push   = 1'b0;
        o_flags.scan   = 1'b0;

        unique case (i_op)
            OP_MARK: begin
                o_bottom = base;
                o_result = base;
            end
            OP_P_ALLOC: begin
                if (space_p) begin
                    o_flags.status = ST_SPACE;
                end else begin
                    o_bottom = base + LW'(i_size);
                    o_result = base;
                end
            end
            OP_P_RESET: begin
                if (SUMW'(i_addr) > SUMW'(i_bottom) || addr_over) begin
                    o_flags.status = ST_BADRESET;
                end else begin
                    o_bottom = LW'(i_addr);
                end
            end
            OP_T_ALLOC: begin
                if (space_t) begin
                    o_flags.status = ST_SPACE;
                end else if (i_count >= CW'(TEMP_SLOTS)) begin
                    o_flags.status = ST_FULL;
                end else begin
                    o_top        = top_new;
                    o_result     = LW'(REGION_BYTES) - top_new;
                    o_flags.push = 1'b1;
                end
            end
            OP_T_FREE: begin
                if (addr_over) begin
                    o_flags.status = ST_NOTFOUND;
                end else begin
                    o_flags.scan = 1'b1;
                end
            end
            OP_T_CHECK: begin
                if (i_top != '0) begin
                    o_flags.status = ST_LIVE;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== hdl/two_ended_hunk_allocator.sv =====
// Two-ended allocator over one region of REGION_BYTES bytes: persistent
// allocations grow up from address 0, temporary ones (rounded to 8 bytes)
// grow down from the top, and a table of up to TEMP_SLOTS live temporary
// offsets sits in a two-read, one-write synchronous RAM. One request is
// handled at a time; a new beat is taken while the previous result still
// waits on the output. Every opcode except temporary free is evaluated in
// S_EXEC and its result is registered once the output is free. A temporary
// free walks the live table through the RAM, a read state then a compare
// state per entry, and reports from S_FIN. The table needs no clearing
// after reset. A failing request leaves all state as it was and reports its
// status; the levels and count on every result are those after the request.
module two_ended_hunk_allocator import tehal_pkg::*; #(
    parameter int REGION_BYTES = 4194304,
    parameter int TEMP_SLOTS   = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_wr_en,
    input  logic      i_cfg_wr_data,
    tehal_req_if.sink   i_req,
    tehal_rsp_if.source o_rsp
);

    localparam int LW = $clog2(REGION_BYTES) + 2;
    localparam int CW = $clog2(TEMP_SLOTS + 1);
    localparam int AW = (TEMP_SLOTS > 1) ? $clog2(TEMP_SLOTS) : 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_RD   = 5'b00100,
        S_EV   = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state r_state;

    logic              r_align;
    logic [LW-1:0]     r_bottom;
    logic [LW-1:0]     r_top;
    logic [CW-1:0]     r_count;

    logic [OP_W-1:0]   r_op;
    logic [ADDR_W-1:0] r_size;
    logic [ADDR_W-1:0] r_addr;

    logic [CW-1:0]     r_i;
    logic [LW-1:0]     r_high;
    logic              r_hit;
    logic [LW-1:0]     r_target;

    logic              r_out_valid;
    logic [ADDR_W-1:0] r_res;
    logic [ST_W-1:0]   r_st;
    logic [ADDR_W-1:0] r_pl;
    logic [ADDR_W-1:0] r_tl;
    logic [CNT_W-1:0]  r_tc;

    logic [LW-1:0] e_bottom;
    logic [LW-1:0] e_top;
    logic [LW-1:0] e_result;
    logic [LW-1:0] e_target;
    t_eval_flags   e_flags;

    logic          out_free;
    logic          commit;
    logic          rsp_load;
    logic          match;
    logic [CW-1:0] last_idx;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [LW-1:0] mem_wdata;
    logic          mem_re;
    logic [LW-1:0] rd_a;
    logic [LW-1:0] rd_b;

    tehal_eval #(
        .REGION_BYTES (REGION_BYTES),
        .TEMP_SLOTS   (TEMP_SLOTS),
        .LW           (LW),
        .CW           (CW)
    ) u_eval (
        .i_op     (r_op),
        .i_size   (r_size),
        .i_addr   (r_addr),
        .i_align  (r_align),
        .i_bottom (r_bottom),
        .i_top    (r_top),
        .i_count  (r_count),
        .o_bottom (e_bottom),
        .o_top    (e_top),
        .o_result (e_result),
        .o_target (e_target),
        .o_flags  (e_flags)
    );

    assign out_free = !r_out_valid || o_rsp.ready;
    assign commit   = (r_state == S_EXEC) && !e_flags.scan && out_free;
    assign rsp_load = commit || ((r_state == S_FIN) && out_free);
    assign match    = rd_a == r_target;
    assign last_idx = r_count - CW'(1);

    // one write port: a push on temporary alloc, or the swap-in of the last
    // entry over a matching one during the free scan
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_count[AW-1:0];
        mem_wdata = e_top;
        if (commit && e_flags.push) begin
            mem_we = 1'b1;
        end else if (r_state == S_EV && match) begin
            mem_we    = 1'b1;
            mem_waddr = r_i[AW-1:0];
            mem_wdata = rd_b;
        end
    end

    assign mem_re = (r_state == S_RD) && (r_i < r_count);

    tehal_mem #(
        .W     (LW),
        .DEPTH (TEMP_SLOTS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_re      (mem_re),
        .i_raddr_a (r_i[AW-1:0]),
        .i_raddr_b (last_idx[AW-1:0]),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_align     <= 1'b0;
            r_bottom    <= '0;
            r_top       <= '0;
            r_count     <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_align <= i_cfg_wr_data;
            end
            if (rsp_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (e_flags.scan) begin
                        r_hit   <= 1'b0;
                        r_state <= S_RD;
                    end else if (out_free) begin
                        r_bottom <= e_bottom;
                        r_top    <= e_top;
                        r_count  <= r_count + CW'(e_flags.push);
                        r_state  <= S_IDLE;
                    end
                end
                S_RD: begin
                    r_state <= mem_re ? S_EV : S_FIN;
                end
                S_EV: begin
                    // on a match the slot now holds the old last entry, so
                    // the same index is read again
                    if (match) begin
                        r_count <= last_idx;
                        r_hit   <= 1'b1;
                    end
                    r_state <= S_RD;
                end
                S_FIN: begin
                    if (out_free) begin
                        if (r_hit) begin
                            r_top <= r_high;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // request beat, scan pointers and result beat
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.valid) begin
            r_op   <= i_req.opcode;
            r_size <= i_req.byte_count;
            r_addr <= i_req.address;
        end
        if (r_state == S_EXEC) begin
            r_i      <= '0;
            r_high   <= '0;
            r_target <= e_target;
        end
        if (r_state == S_EV && !match) begin
            r_i <= r_i + CW'(1);
            if (rd_a > r_high) begin
                r_high <= rd_a;
            end
        end
        if (commit) begin
            r_res <= ADDR_W'(e_result);
            r_st  <= e_flags.status;
            r_pl  <= ADDR_W'(e_bottom);
            r_tl  <= ADDR_W'(e_top);
            r_tc  <= CNT_W'(r_count + CW'(e_flags.push));
        end else if (r_state == S_FIN && out_free) begin
            r_res <= '0;
            r_st  <= r_hit ? ST_OK : ST_NOTFOUND;
            r_pl  <= ADDR_W'(r_bottom);
            r_tl  <= ADDR_W'(r_hit ? r_high : r_top);
            r_tc  <= CNT_W'(r_count);
        end
    end

    assign i_req.ready = (r_state == S_IDLE);

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.result_address   = r_res;
    assign o_rsp.status           = r_st;
    assign o_rsp.persistent_level = r_pl;
    assign o_rsp.temp_level       = r_tl;
    assign o_rsp.temp_count       = r_tc;

endmodule
